>>> rtl/hex_text_byte_parser_core_macros.svh
// Assertion macros for the hex text byte parser.
`ifndef HEX_TEXT_BYTE_PARSER_CORE_MACROS_SVH
`define HEX_TEXT_BYTE_PARSER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HTBP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hex parser assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define HTBP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hex parser assertion failed");

`endif

>>> rtl/hexp_pkg.sv
// Types, character codes and structs shared by the hex text byte parser.
`default_nettype none
package hexp_pkg;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [3:0] NibTen  = 4'd10;

  typedef enum logic [1:0] {
    PH_GAP    = 2'd0,
    PH_ZERO   = 2'd1,
    PH_PREFIX = 2'd2,
    PH_DIGITS = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BAD    = 3'd1,
    ST_ODD    = 3'd2,
    ST_PREFIX = 3'd3,
    ST_EMPTY  = 3'd4
  } status_e;

  typedef struct packed {
    logic       is_hex;
    logic       is_sep;
    logic       is_zero;
    logic       is_x;
    logic [3:0] nibble;
  } char_class_t;

  typedef struct packed {
    phase_e     phase;
    logic [3:0] held_nibble;
    logic       half_byte;
    status_e    error_code;
    logic       byte_seen;
  } parse_state_t;

  localparam parse_state_t StateReset = '{
    phase:       PH_GAP,
    held_nibble: 4'd0,
    half_byte:   1'b0,
    error_code:  ST_OK,
    byte_seen:   1'b0
  };

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       parse_done;
    status_e    parse_status;
  } parse_result_t;

endpackage
`default_nettype wire

>>> rtl/hexp_class.sv
// Character classifier: hex digit value, separator, zero and x detection.
`default_nettype none
module hexp_class (
  input  wire logic [7:0]           char_i,
  output hexp_pkg::char_class_t     class_o
);
  import hexp_pkg::*;

  always_comb begin
    class_o = '0;
    class_o.is_zero = (char_i == ChZero);
    class_o.is_x    = (char_i == ChLowX) || (char_i == ChUpX);
    class_o.is_sep  = (char_i inside {[ChTab:ChCr], ChSpace, ChDash, ChComma, ChColon});
    if (char_i inside {[ChZero:ChNine]}) begin
      class_o.is_hex = 1'b1;
      class_o.nibble = 4'(char_i - ChZero);
    end else if (char_i inside {[ChLowA:ChLowF]}) begin
      class_o.is_hex = 1'b1;
      class_o.nibble = 4'(char_i - ChLowA) + NibTen;
    end else if (char_i inside {[ChUpA:ChUpF]}) begin
      class_o.is_hex = 1'b1;
      class_o.nibble = 4'(char_i - ChUpA) + NibTen;
    end
  end

endmodule
`default_nettype wire

>>> rtl/hexp_step.sv
// Per-character parser update: next token state, formed byte and final status.
`default_nettype none
module hexp_step (
  input  wire hexp_pkg::parse_state_t  state_i,
  input  wire hexp_pkg::char_class_t   class_i,
  input  wire logic                    last_i,
  output hexp_pkg::parse_state_t       state_o,
  output hexp_pkg::parse_result_t      result_o
);
  import hexp_pkg::*;

  parse_state_t nxt;
  status_e      err_new;
  status_e      err_body;
  status_e      err_end;
  status_e      err_final;
  logic         formed;
  logic         formed_ok;
  logic [7:0]   value;
  logic         seen;

  always_comb begin
    nxt     = state_i;
    err_new = ST_OK;
    formed  = 1'b0;
    value   = 8'd0;

    case (state_i.phase)
      PH_GAP: begin
        if (class_i.is_sep) begin
          nxt.phase = PH_GAP;
        end else if (class_i.is_zero) begin
          nxt.phase       = PH_ZERO;
          nxt.held_nibble = 4'd0;
          nxt.half_byte   = 1'b1;
        end else if (class_i.is_hex) begin
          nxt.phase       = PH_DIGITS;
          nxt.held_nibble = class_i.nibble;
          nxt.half_byte   = 1'b1;
        end else begin
          err_new = ST_BAD;
        end
      end
      PH_ZERO: begin
        if (class_i.is_x) begin
          nxt.phase       = PH_PREFIX;
          nxt.held_nibble = 4'd0;
          nxt.half_byte   = 1'b0;
        end else if (class_i.is_hex) begin
          formed        = 1'b1;
          value         = {4'd0, class_i.nibble};
          nxt.phase     = PH_DIGITS;
          nxt.half_byte = 1'b0;
        end else begin
          err_new       = ST_ODD;
          nxt.phase     = PH_GAP;
          nxt.half_byte = 1'b0;
        end
      end
      PH_PREFIX: begin
        if (class_i.is_hex) begin
          nxt.phase       = PH_DIGITS;
          nxt.held_nibble = class_i.nibble;
          nxt.half_byte   = 1'b1;
        end else begin
          err_new   = ST_PREFIX;
          nxt.phase = PH_GAP;
        end
      end
      PH_DIGITS: begin
        if (class_i.is_hex) begin
          if (state_i.half_byte) begin
            formed        = 1'b1;
            value         = {state_i.held_nibble, class_i.nibble};
            nxt.half_byte = 1'b0;
          end else begin
            nxt.held_nibble = class_i.nibble;
            nxt.half_byte   = 1'b1;
          end
        end else begin
          if (state_i.half_byte) begin
            err_new = ST_ODD;
          end else if (!class_i.is_sep) begin
            err_new = ST_BAD;
          end
          nxt.phase     = PH_GAP;
          nxt.half_byte = 1'b0;
        end
      end
      default: begin
        nxt = state_i;
      end
    endcase

    // First error wins.
    err_body  = (state_i.error_code != ST_OK) ? state_i.error_code : err_new;
    formed_ok = formed && (err_body == ST_OK);
    seen      = state_i.byte_seen | formed_ok;
    nxt.error_code = err_body;
    nxt.byte_seen  = seen;

    // Close the open token at the end of the text.
    if ((nxt.phase == PH_ZERO) || ((nxt.phase == PH_DIGITS) && nxt.half_byte)) begin
      err_end = ST_ODD;
    end else if (nxt.phase == PH_PREFIX) begin
      err_end = ST_PREFIX;
    end else begin
      err_end = ST_OK;
    end
    err_final = (err_body != ST_OK) ? err_body : err_end;

    result_o.byte_valid   = formed_ok;
    result_o.byte_value   = formed_ok ? value : 8'd0;
    result_o.parse_done   = last_i;
    result_o.parse_status = ST_OK;
    if (last_i) begin
      if (err_final != ST_OK) begin
        result_o.parse_status = err_final;
      end else begin
        result_o.parse_status = seen ? ST_OK : ST_EMPTY;
      end
    end

    state_o = last_i ? StateReset : nxt;
  end

endmodule
`default_nettype wire

>>> rtl/hex_text_byte_parser_core.sv
// Top level of the streaming hex text byte parser.
// Streaming hex byte parser: one text character enters per word on the input
// channel and exactly one result word leaves for it. Tokens are split by
// whitespace (tab through carriage return, space), '-', ',' or ':'; a token
// may open with 0x or 0X, digits may be either case, and each digit pair
// gives one byte (first digit is the high nibble). The first error is latched
// and byte_valid stays low after it; the word for the last character carries
// parse_done and the final status (0 ok, 1 bad character, 2 odd digit count,
// 3 prefix without digits, 4 no bytes), after which the parser starts a fresh
// text. Bytes leave as they form, so drop them all when the status is not ok.
// Throughput is one character per clock while the output is not stalled; each
// character passes through the input register and then the result register,
// with the classifier and state update between them. A stalled result holds
// while the input register still takes the next character if it is empty.
`default_nettype none
module hex_text_byte_parser_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_text_char_i,
  input  wire logic       in_text_end_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            out_byte_valid_o,
  output logic [7:0]      out_byte_value_o,
  output logic            out_parse_done_o,
  output logic [2:0]      out_parse_status_o
);
  import hexp_pkg::*;

  // Input register.
  logic          s1_valid_q;
  logic [7:0]    s1_char_q;
  logic          s1_last_q;
  logic          s1_adv;
  logic          in_take;

  // Token state and result register.
  parse_state_t  state_q;
  parse_state_t  state_d;
  char_class_t   char_class;
  parse_result_t result_d;
  parse_result_t result_q;
  logic          out_valid_q;

  // Advance the input word whenever the result register is free or drains.
  assign s1_adv     = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_char_q <= in_text_char_i;
      s1_last_q <= in_text_end_i;
    end
  end

  hexp_class u_class (
    .char_i  (s1_char_q),
    .class_o (char_class)
  );

  hexp_step u_step (
    .state_i  (state_q),
    .class_i  (char_class),
    .last_i   (s1_last_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Commit the state only when the character moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (s1_adv) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_byte_valid_o   = result_q.byte_valid;
  assign out_byte_value_o   = result_q.byte_value;
  assign out_parse_done_o   = result_q.parse_done;
  assign out_parse_status_o = 3'(result_q.parse_status);

`include "hex_text_byte_parser_core_macros.svh"

  // A failing status never rides with a fresh byte.
  `HTBP_ASSERT_IMP(a_err_no_byte, clk_i, rst_ni, out_valid_o && out_parse_done_o && (out_parse_status_o != 3'(ST_OK)), !out_byte_valid_o)
  // Status is reported only on the final word.
  `HTBP_ASSERT_IMP(a_status_on_done, clk_i, rst_ni, out_valid_o && !out_parse_done_o, out_parse_status_o == 3'(ST_OK))
  // The last character returns the parser to its reset state.
  `HTBP_ASSERT_NXT(a_end_resets, clk_i, rst_ni, s1_adv && s1_last_q, (state_q.phase == PH_GAP) && (state_q.error_code == ST_OK) && !state_q.byte_seen)
  // Stall the input only while a word waits in the input register.
  `HTBP_ASSERT_IMP(a_stall_needs_word, clk_i, rst_ni, in_stall_o, s1_valid_q && out_valid_q)

endmodule
`default_nettype wire

>>> tb/hex_text_byte_parser_checker.sv
// Checker for the hex text byte parser: predicts each result word and compares it.
`timescale 1ns / 100ps
module hex_text_byte_parser_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_stall_i,
  input  wire logic [7:0] in_text_char_i,
  input  wire logic       in_text_end_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_stall_i,
  input  wire logic       out_byte_valid_i,
  input  wire logic [7:0] out_byte_value_i,
  input  wire logic       out_parse_done_i,
  input  wire logic [2:0] out_parse_status_i,
  output int              mismatch_count_o,
  output int              words_due_o
);
  import hexp_pkg::*;

  parse_result_t byte_words_due[$];
  phase_e        text_phase;
  logic [3:0]    pair_nibble;
  logic          pair_open;
  status_e       latched_status;
  logic          text_has_byte;
  int            mismatches;

  task automatic clear_text_state();
    text_phase     = PH_GAP;
    pair_nibble    = 4'd0;
    pair_open      = 1'b0;
    latched_status = ST_OK;
    text_has_byte  = 1'b0;
  endtask

  // Keep the first error of the text.
  task automatic note_error(input status_e code);
    if (latched_status == ST_OK) latched_status = code;
  endtask

  task automatic parse_char(input logic [7:0] c, input logic last);
    logic          is_gap;
    logic          is_hex;
    logic          formed;
    logic [3:0]    nib;
    logic [7:0]    value;
    parse_result_t res;
    is_gap = (c >= ChTab && c <= ChCr) || c == ChSpace || c == ChDash ||
             c == ChComma || c == ChColon;
    is_hex = 1'b1;
    nib    = 4'd0;
    if (c >= ChZero && c <= ChNine) nib = 4'(c - ChZero);
    else if (c >= ChLowA && c <= ChLowF) nib = 4'(c - ChLowA) + NibTen;
    else if (c >= ChUpA && c <= ChUpF) nib = 4'(c - ChUpA) + NibTen;
    else is_hex = 1'b0;
    formed = 1'b0;
    value  = 8'd0;
    case (text_phase)
      PH_GAP: begin
        if (is_gap) begin
        end else if (c == ChZero) begin
          text_phase = PH_ZERO;
          pair_nibble = 4'd0;
          pair_open = 1'b1;
        end else if (is_hex) begin
          text_phase = PH_DIGITS;
          pair_nibble = nib;
          pair_open = 1'b1;
        end else begin
          note_error(ST_BAD);
        end
      end
      PH_ZERO: begin
        if (c == ChLowX || c == ChUpX) begin
          text_phase = PH_PREFIX;
          pair_nibble = 4'd0;
          pair_open = 1'b0;
        end else if (is_hex) begin
          value = {4'd0, nib};
          formed = 1'b1;
          text_phase = PH_DIGITS;
          pair_open = 1'b0;
        end else begin
          note_error(ST_ODD);
          text_phase = PH_GAP;
          pair_open = 1'b0;
        end
      end
      PH_PREFIX: begin
        if (is_hex) begin
          text_phase = PH_DIGITS;
          pair_nibble = nib;
          pair_open = 1'b1;
        end else begin
          note_error(ST_PREFIX);
          text_phase = PH_GAP;
        end
      end
      default: begin
        if (is_hex) begin
          if (pair_open) begin
            value = {pair_nibble, nib};
            formed = 1'b1;
            pair_open = 1'b0;
          end else begin
            pair_nibble = nib;
            pair_open = 1'b1;
          end
        end else begin
          if (pair_open) note_error(ST_ODD);
          else if (!is_gap) note_error(ST_BAD);
          text_phase = PH_GAP;
          pair_open = 1'b0;
        end
      end
    endcase
    if (formed && latched_status != ST_OK) formed = 1'b0;
    if (formed) text_has_byte = 1'b1;
    res.byte_valid   = formed;
    res.byte_value   = formed ? value : 8'd0;
    res.parse_done   = last;
    res.parse_status = ST_OK;
    if (last) begin
      // Close the open token, then report.
      if (text_phase == PH_ZERO || (text_phase == PH_DIGITS && pair_open))
        note_error(ST_ODD);
      else if (text_phase == PH_PREFIX)
        note_error(ST_PREFIX);
      if (latched_status != ST_OK) res.parse_status = latched_status;
      else res.parse_status = text_has_byte ? ST_OK : ST_EMPTY;
      clear_text_state();
    end
    byte_words_due.insert(byte_words_due.size(), res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    parse_result_t want;
    if (!rst_ni) begin
      byte_words_due.delete();
      clear_text_state();
      mismatches = 0;
      mismatch_count_o <= 0;
      words_due_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (byte_words_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result word %0b/%02h/%0b/%0d",
                     $realtime, out_byte_valid_i, out_byte_value_i, out_parse_done_i,
                     out_parse_status_i);
        end else begin
          want = byte_words_due.pop_front();
          if (want.byte_valid !== out_byte_valid_i || want.byte_value !== out_byte_value_i ||
              want.parse_done !== out_parse_done_i ||
              3'(want.parse_status) !== out_parse_status_i) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected %0b/%02h/%0b/%0d got %0b/%02h/%0b/%0d",
                       $realtime, want.byte_valid, want.byte_value, want.parse_done,
                       3'(want.parse_status), out_byte_valid_i, out_byte_value_i,
                       out_parse_done_i, out_parse_status_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) parse_char(in_text_char_i, in_text_end_i);
      mismatch_count_o <= mismatches;
      words_due_o <= byte_words_due.size();
    end
  end

endmodule

>>> tb/tb_hex_text_byte_parser_core.sv
// Testbench top for the hex text byte parser: stimulus, stall control and verdict.
`timescale 1ns / 100ps
module tb_hex_text_byte_parser_core;
  import hexp_pkg::*;

  // Abort once this many cycles pass with no word moving on either channel.
  localparam int WatchdogLimit = 4000;
  // Cycles to linger after the last expected word.
  localparam int TailCycles    = 10;
  // Characters sent per random phase.
  localparam int PhaseChars    = 200;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_text_char_i = 8'd0;
  logic       in_text_end_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       out_byte_valid_o;
  logic [7:0] out_byte_value_o;
  logic       out_parse_done_o;
  logic [2:0] out_parse_status_o;

  int         mismatch_count;
  int         words_due;
  int         idle_cycles = 0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         chars_sent = 0;
  logic [7:0] text_buf[$];

  // Every character that separates tokens.
  logic [7:0] gap_chars[9] = '{ChTab, 8'h0A, 8'h0B, 8'h0C, ChCr, ChSpace,
                               ChDash, ChComma, ChColon};

  hex_text_byte_parser_core i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_text_char_i,
    .in_text_end_i,
    .out_valid_o,
    .out_stall_i,
    .out_byte_valid_o,
    .out_byte_value_o,
    .out_parse_done_o,
    .out_parse_status_o
  );

  // The checker watches both channels beside the block and counts failures.
  hex_text_byte_parser_checker i_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i         (in_stall_o),
    .in_text_char_i,
    .in_text_end_i,
    .out_valid_i        (out_valid_o),
    .out_stall_i,
    .out_byte_valid_i   (out_byte_valid_o),
    .out_byte_value_i   (out_byte_value_o),
    .out_parse_done_i   (out_parse_done_o),
    .out_parse_status_i (out_parse_status_o),
    .mismatch_count_o   (mismatch_count),
    .words_due_o        (words_due)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Receiver side: stall at random, at the rate the current phase sets.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: restart the count on any accepted word, give up when it runs out.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("tb_hex_text_byte_parser_core NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic logic [7:0] gap_char();
    return gap_chars[$urandom_range(8)];
  endfunction

  // Pick a random hex digit in a random case.
  function automatic logic [7:0] digit_char();
    logic [3:0] n;
    n = 4'($urandom_range(15));
    if (n < NibTen) return ChZero + 8'(n);
    return ($urandom_range(1) ? ChUpA : ChLowA) + 8'(n - NibTen);
  endfunction

  // Append one character to the text being built.
  task automatic append_char(input logic [7:0] c);
    text_buf.insert(text_buf.size(), c);
  endtask

  // Hand one word to the block: idle first at random, then hold the word until taken.
  task automatic send_word(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_text_char_i <= c;
    in_text_end_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    chars_sent++;
  endtask

  // Send the buffered text, marking its final character.
  task automatic send_text();
    foreach (text_buf[i]) send_word(text_buf[i], i == text_buf.size() - 1);
  endtask

  task automatic send_string(input string s);
    text_buf.delete();
    foreach (s[i]) append_char(s[i]);
    send_text();
  endtask

  // Build one random text. Most texts are well formed with random content;
  // some are pure noise and some carry a single corruption.
  task automatic build_text();
    int kind;
    int pos;
    kind = $urandom_range(9);
    text_buf.delete();
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) append_char(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(0, 1)) append_char(gap_char());
      for (int t = 0; t < $urandom_range(1, 4); t++) begin
        if (t > 0) repeat ($urandom_range(1, 2)) append_char(gap_char());
        if ($urandom_range(2) == 0) begin
          append_char(ChZero);
          append_char($urandom_range(1) ? ChUpX : ChLowX);
        end
        repeat ($urandom_range(1, 3)) begin
          append_char(digit_char());
          append_char(digit_char());
        end
      end
      if ($urandom_range(3) == 0) append_char(gap_char());
      if (kind >= 7) begin
        pos = $urandom_range(text_buf.size() - 1);
        case ($urandom_range(3))
          0: text_buf[pos] = 8'($urandom_range(255));
          1: if (text_buf.size() > 1) text_buf.delete(pos);
          2: text_buf.insert(pos, 8'($urandom_range(255)));
          default: begin
            // Drop in a bare prefix token.
            text_buf.insert(pos, gap_char());
            text_buf.insert(pos, ChLowX);
            text_buf.insert(pos, ChZero);
          end
        endcase
      end
    end
  endtask

  initial begin
    // Hold reset from the start, then release it once for the whole run.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed texts, no idling.
    send_string("0xAb,9F");   // prefix, mixed case, two bytes
    send_string("0");         // single character: lone zero is an odd digit count
    text_buf = '{8'hFF};      // top character code, bad at token start
    send_text();
    text_buf = '{8'h00};      // bottom character code
    send_text();
    send_string("0X");        // prefix with no digits at end of text
    send_string("01 2");      // leading zero read as a digit, then an odd token
    send_string("abg\t");     // token ended by a stray character after its byte left
    send_string(" ");         // separators only: no bytes
    send_string("g5");        // first error wins over the later odd count

    // Random texts across the idling phases.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 61; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 61; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      chars_sent = 0;
      while (chars_sent < PhaseChars) begin
        build_text();
        send_text();
      end
    end
    in_valid_i <= 1'b0;

    // Drain: wait for every predicted word, then linger for stray ones.
    @(posedge clk_i);
    while (words_due != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_hex_text_byte_parser_core OK");
    end else begin
      $display("tb_hex_text_byte_parser_core NOT OK");
    end
    $finish;
  end

endmodule
